FILE: sv/rtcms_pkg.sv
// Shared types, sizes and helpers for the row table column match search block.
// No dependencies.
package rtcms_pkg;

	localparam int MAX_ROWS    = 1024;
	localparam int NUM_COLUMNS = 5;
	localparam int CELL_WORDS  = 16;

	localparam int ROW_WORDS   = NUM_COLUMNS * CELL_WORDS;
	localparam int STORE_DEPTH = MAX_ROWS * ROW_WORDS;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int SA_W        = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
	localparam int WI_W        = (CELL_WORDS > 1) ? $clog2(CELL_WORDS) : 1;
	localparam int CNT_W       = $clog2(MAX_ROWS + 1);

	localparam int COL_W    = 3;
	localparam int WIDX_W   = 4;
	localparam int WORD_W   = 64;
	localparam int STATUS_W = 2;
	localparam int IDX_W    = 10;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);

	typedef enum logic [STATUS_W-1:0] {
		ST_STORED  = 2'd0,
		ST_FULL    = 2'd1,
		ST_FOUND   = 2'd2,
		ST_NOMATCH = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMP_MORE = 2'd0,
		CMP_HIT  = 2'd1,
		CMP_MISS = 2'd2
	} cmp_t;

	// decoded item passed from front to back
	typedef struct packed {
		logic              is_query;
		logic              last;
		logic              wr_en;
		logic              col_ok;
		logic [COL_W-1:0]  col;
		logic [WI_W-1:0]   widx;
		logic [WORD_W-1:0] word;
	} cmd_t;

	// compare one cell word against one query word, bytes in order
	function automatic cmp_t word_cmp(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
		cmp_t r;
		logic done;
		r    = CMP_MORE;
		done = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!done) begin
				if (a[8*i +: 8] != b[8*i +: 8]) begin
					r    = CMP_MISS;
					done = 1'b1;
				end else if (a[8*i +: 8] == 8'd0) begin
					r    = CMP_HIT;
					done = 1'b1;
				end
			end
		end
		return r;
	endfunction

endpackage

FILE: sv/rtcms_front.sv
// Front end: decodes input items and queues them for the back end.
// Depends on rtcms_pkg.
module rtcms_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         req_type,
	input  logic [rtcms_pkg::COL_W-1:0]  column,
	input  logic [rtcms_pkg::WIDX_W-1:0] word_index,
	input  logic [rtcms_pkg::WORD_W-1:0] cell_word,
	input  logic                         last,
	output logic                         cmd_valid,
	output rtcms_pkg::cmd_t              cmd,
	input  logic                         cmd_take
);
	import rtcms_pkg::*;

	cmd_t                cmdq_q [CMDQ_DEPTH];
	logic [CMDQ_PW-1:0]  wp_q, rp_q;
	logic [CMDQ_PW:0]    cnt_q;
	cmd_t                dec;
	logic                wi_ok, col_ok, do_push, do_pop;

	always_comb begin
		wi_ok        = 32'(word_index) < CELL_WORDS;
		col_ok       = 32'(column) < NUM_COLUMNS;
		dec.is_query = req_type;
		dec.last     = last;
		dec.wr_en    = wi_ok && (req_type || col_ok);
		dec.col_ok   = col_ok;
		dec.col      = column;
		dec.widx     = WI_W'(word_index);
		dec.word     = cell_word;
	end

	assign full      = cnt_q == (CMDQ_PW+1)'(CMDQ_DEPTH);
	assign cmd_valid = cnt_q != '0;
	assign cmd       = cmdq_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			cmdq_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (do_pop)  rp_q <= rp_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: sv/rtcms_back.sv
// Back end: staging row, query buffer, row store, append copy and scan.
// Depends on rtcms_pkg.
module rtcms_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  rtcms_pkg::cmd_t                cmd,
	output logic                           cmd_take,
	output logic                           res_valid,
	output logic [rtcms_pkg::STATUS_W-1:0] res_status,
	output logic [rtcms_pkg::IDX_W-1:0]    res_index,
	input  logic                           res_take
);
	import rtcms_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_COPY_RD = 5'b00010,
		S_COPY_WR = 5'b00100,
		S_SCAN_RD = 5'b01000,
		S_SCAN_CM = 5'b10000
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    row_count_q;
	logic [ADDR_W-1:0]   row_base_q;
	logic [CNT_W-1:0]    scan_row_q;
	logic [ADDR_W-1:0]   scan_addr_q;
	logic [WI_W-1:0]     w_q;
	logic [SA_W-1:0]     k_q;
	logic                rv_q;
	status_t             rs_q;
	logic [IDX_W-1:0]    ri_q;

	logic [WORD_W-1:0]   stage_mem [ROW_WORDS];
	logic [ROW_WORDS-1:0] stage_vld_q;
	logic [WORD_W-1:0]   stage_rd_q;
	logic                stage_vld_rd_q;
	logic [WORD_W-1:0]   query_q [CELL_WORDS];
	logic [WORD_W-1:0]   store_mem [STORE_DEPTH];
	logic [WORD_W-1:0]   store_rd_q;

	logic                take, stage_we, store_we, query_we, query_clr, stage_clr;
	logic [SA_W-1:0]     stage_wa;
	logic [ADDR_W-1:0]   store_wa, store_ra;
	cmp_t                cmp;

	assign take     = state_q == S_IDLE && cmd_valid && (!cmd.last || !rv_q);
	assign cmd_take = take;
	assign stage_we = take && !cmd.is_query && cmd.wr_en;
	assign stage_wa = SA_W'(32'(cmd.col) * CELL_WORDS + 32'(cmd.widx));
	assign query_we = take && cmd.is_query && cmd.wr_en;
	assign store_we = state_q == S_COPY_WR;
	assign store_wa = row_base_q + ADDR_W'(k_q);
	assign store_ra = scan_addr_q + ADDR_W'(w_q);
	assign cmp      = word_cmp(store_rd_q, query_q[w_q]);

	assign res_valid  = rv_q;
	assign res_status = rs_q;
	assign res_index  = ri_q;

	// staging row storage; words not written are copied to the row store as zero
	always_ff @(posedge clk) begin
		if (stage_we) stage_mem[stage_wa] <= cmd.word;
		stage_rd_q     <= stage_mem[k_q];
		stage_vld_rd_q <= stage_vld_q[k_q];
	end

	always_ff @(posedge clk) begin
		if (store_we) store_mem[store_wa] <= stage_vld_rd_q ? stage_rd_q : '0;
		store_rd_q <= store_mem[store_ra];
	end

	always_comb begin
		stage_clr = 1'b0;
		query_clr = 1'b0;
		if (take && cmd.last && !cmd.is_query && 32'(row_count_q) >= MAX_ROWS) stage_clr = 1'b1;
		if (state_q == S_COPY_WR && k_q == SA_W'(ROW_WORDS - 1)) stage_clr = 1'b1;
		if (take && cmd.last && cmd.is_query && (!cmd.col_ok || row_count_q == '0))
			query_clr = 1'b1;
		if (state_q == S_SCAN_CM) begin
			if (cmp == CMP_HIT || (cmp == CMP_MORE && w_q == WI_W'(CELL_WORDS - 1)))
				query_clr = 1'b1;
			else if (cmp == CMP_MISS && scan_row_q + 1'b1 == row_count_q)
				query_clr = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
			for (int i = 0; i < CELL_WORDS; i++) query_q[i] <= '0;
		end else begin
			if (stage_clr) stage_vld_q <= '0;
			else if (stage_we) stage_vld_q[stage_wa] <= 1'b1;
			if (query_clr) begin
				for (int i = 0; i < CELL_WORDS; i++) query_q[i] <= '0;
			end else if (query_we) begin
				query_q[cmd.widx] <= cmd.word;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_count_q <= '0;
			row_base_q  <= '0;
			scan_row_q  <= '0;
			scan_addr_q <= '0;
			w_q         <= '0;
			k_q         <= '0;
			rv_q        <= 1'b0;
			rs_q        <= ST_STORED;
			ri_q        <= '0;
		end else begin
			if (res_take && rv_q) rv_q <= 1'b0;
			case (state_q)
			S_IDLE: begin
				if (take && cmd.last) begin
					if (!cmd.is_query) begin
						if (32'(row_count_q) < MAX_ROWS) begin
							k_q     <= '0;
							state_q <= S_COPY_RD;
						end else begin
							rv_q <= 1'b1;
							rs_q <= ST_FULL;
							ri_q <= '0;
						end
					end else if (cmd.col_ok && row_count_q != '0) begin
						scan_row_q  <= '0;
						scan_addr_q <= ADDR_W'(32'(cmd.col) * CELL_WORDS);
						w_q         <= '0;
						state_q     <= S_SCAN_RD;
					end else begin
						rv_q <= 1'b1;
						rs_q <= ST_NOMATCH;
						ri_q <= '0;
					end
				end
			end
			S_COPY_RD: state_q <= S_COPY_WR;
			S_COPY_WR: begin
				if (k_q == SA_W'(ROW_WORDS - 1)) begin
					rv_q        <= 1'b1;
					rs_q        <= ST_STORED;
					ri_q        <= IDX_W'(row_count_q);
					row_count_q <= row_count_q + 1'b1;
					row_base_q  <= row_base_q + ADDR_W'(ROW_WORDS);
					state_q     <= S_IDLE;
				end else begin
					k_q     <= k_q + 1'b1;
					state_q <= S_COPY_RD;
				end
			end
			S_SCAN_RD: state_q <= S_SCAN_CM;
			S_SCAN_CM: begin
				if (cmp == CMP_HIT || (cmp == CMP_MORE && w_q == WI_W'(CELL_WORDS - 1))) begin
					rv_q    <= 1'b1;
					rs_q    <= ST_FOUND;
					ri_q    <= IDX_W'(scan_row_q);
					state_q <= S_IDLE;
				end else if (cmp == CMP_MORE) begin
					w_q     <= w_q + 1'b1;
					state_q <= S_SCAN_RD;
				end else if (scan_row_q + 1'b1 == row_count_q) begin
					rv_q    <= 1'b1;
					rs_q    <= ST_NOMATCH;
					ri_q    <= '0;
					state_q <= S_IDLE;
				end else begin
					scan_row_q  <= scan_row_q + 1'b1;
					scan_addr_q <= scan_addr_q + ADDR_W'(ROW_WORDS);
					w_q         <= '0;
					state_q     <= S_SCAN_RD;
				end
			end
			default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/row_table_column_match_search_top.sv
// Top level of the row table column match search block.
// Depends on rtcms_pkg, rtcms_front and rtcms_back.
//
// Usage:
//  - Input side is a queue: drive the item fields and push; a transfer
//    happens on a clock edge with push high and full low.
//  - Insert words (req_type 0) land in a staging row; the word with last
//    set appends the row (status 0, row index) or drops it when the table
//    holds MAX_ROWS rows (status 1).
//  - Query words (req_type 1) fill a query buffer; the word with last set
//    scans stored rows in insertion order and reports the first row whose
//    cell in the given column matches (status 2) or status 3.
//  - Output side is a queue: the result sits on status/row_index while
//    empty is low and is removed by a transfer with pop high.
//  - Items sit in a four-entry command queue; word loads retire one per
//    cycle while the back end is idle. An append copies the staging row
//    word by word (one staging read and one row store write per word). A
//    query end compares one word at a time through the single row store
//    read port, over all rows scanned until the first match.
//  - A stalled receiver holds the one-deep result register; word loads
//    keep flowing, and the next ending item waits in the command queue.
//  - Reset clears the row count, staging row and query buffer; no
//    clearing pass is needed.
module row_table_column_match_search_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           req_type,
	input  logic [rtcms_pkg::COL_W-1:0]    column,
	input  logic [rtcms_pkg::WIDX_W-1:0]   word_index,
	input  logic [rtcms_pkg::WORD_W-1:0]   cell_word,
	input  logic                           last,
	output logic                           empty,
	input  logic                           pop,
	output logic [rtcms_pkg::STATUS_W-1:0] status,
	output logic [rtcms_pkg::IDX_W-1:0]    row_index
);
	import rtcms_pkg::*;

	cmd_t cmd;
	logic cmd_valid, cmd_take, res_valid;

	rtcms_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.column     (column),
		.word_index (word_index),
		.cell_word  (cell_word),
		.last       (last),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take)
	);

	rtcms_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take),
		.res_valid  (res_valid),
		.res_status (status),
		.res_index  (row_index),
		.res_take   (pop)
	);

	assign empty = !res_valid;

endmodule
